>>> hdl/sitda_pkg.sv
// Package for the signed integer to decimal ASCII core.
// Holds the pipeline payload type, character constants and the BCD shift step.
// No dependencies.
`timescale 1ns / 1ps

package sitda_pkg;

    localparam int VALUE_W        = 32;
    localparam int NUM_DIGITS     = 10;
    localparam int BCD_W          = 4 * NUM_DIGITS;
    localparam int BITS_PER_STAGE = 8;
    localparam int NUM_STAGES     = VALUE_W / BITS_PER_STAGE;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;

    typedef logic [3:0] t_idx;

    typedef struct packed {
        logic               valid;
        logic               neg;
        logic [VALUE_W-1:0] bin;
        logic [BCD_W-1:0]   bcd;
    } t_dd;

    // One double-dabble step: adjust every digit, then shift in one binary bit.
    function automatic logic [BCD_W-1:0] dd_shift(input logic [BCD_W-1:0] bcd,
                                                  input logic           b);
        logic [BCD_W-1:0] adj;
        adj = bcd;
        for (int d = 0; d < NUM_DIGITS; d++) begin
            if (bcd[4*d +: 4] >= 4'd5) begin
                adj[4*d +: 4] = bcd[4*d +: 4] + 4'd3;
            end
        end
        return {adj[BCD_W-2:0], b};
    endfunction

    // Index of the most significant nonzero digit, zero when all digits are zero.
    function automatic t_idx top_digit(input logic [BCD_W-1:0] bcd);
        t_idx idx;
        idx = '0;
        for (int d = 0; d < NUM_DIGITS; d++) begin
            if (bcd[4*d +: 4] != 4'd0) begin
                idx = t_idx'(d);
            end
        end
        return idx;
    endfunction

endpackage

>>> hdl/sitda_dabble_stage.sv
// One pipeline stage of the binary to BCD converter: eight shift-add-3 steps.
// Depends on sitda_pkg.
`timescale 1ns / 1ps

module sitda_dabble_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  sitda_pkg::t_dd i_stage,
    input  logic           i_ready,
    output sitda_pkg::t_dd o_stage,
    output logic           o_ready
);
    import sitda_pkg::*;

    t_dd                r_stage;
    t_dd                n_stage;
    logic [BCD_W-1:0]   w_bcd;
    logic [VALUE_W-1:0] w_bin;

    always_comb begin
        w_bcd = i_stage.bcd;
        w_bin = i_stage.bin;
        for (int k = 0; k < BITS_PER_STAGE; k++) begin
            w_bcd = dd_shift(w_bcd, w_bin[VALUE_W-1]);
            w_bin = {w_bin[VALUE_W-2:0], 1'b0};
        end
        n_stage       = i_stage;
        n_stage.bcd   = w_bcd;
        n_stage.bin   = w_bin;
    end

    assign o_ready = !r_stage.valid || i_ready;
    assign o_stage = r_stage;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage.valid <= 1'b0;
        end else if (o_ready) begin
            r_stage <= n_stage;
        end
    end

endmodule

>>> hdl/sitda_serializer.sv
// Emits the sign and the significant BCD digits as ASCII, one per cycle.
// Depends on sitda_pkg.
`timescale 1ns / 1ps

module sitda_serializer (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  sitda_pkg::t_dd i_stage,
    output logic           o_ready,
    output logic           o_strobe,
    output logic [7:0]     o_character,
    output logic           o_last_char
);
    import sitda_pkg::*;

    logic             r_active;
    logic             r_neg_pend;
    t_idx             r_idx;
    logic [BCD_W-1:0] r_bcd;
    logic             n_active;
    logic             n_neg_pend;
    t_idx             n_idx;
    logic [BCD_W-1:0] n_bcd;
    logic             w_last;
    logic [3:0]       w_digit;

    assign w_last      = r_active && !r_neg_pend && (r_idx == '0);
    assign w_digit     = r_bcd[{r_idx, 2'b00} +: 4];
    assign o_ready     = !r_active || w_last;
    assign o_strobe    = r_active;
    assign o_last_char = w_last;
    assign o_character = r_neg_pend ? CHAR_MINUS : (CHAR_ZERO + {4'b0000, w_digit});

    always_comb begin
        n_active   = r_active;
        n_neg_pend = r_neg_pend;
        n_idx      = r_idx;
        n_bcd      = r_bcd;
        if (r_active) begin
            if (r_neg_pend) begin
                n_neg_pend = 1'b0;
            end else if (r_idx != '0) begin
                n_idx = r_idx - t_idx'(1);
            end else begin
                n_active = 1'b0;
            end
        end
        if (i_stage.valid && o_ready) begin
            n_active   = 1'b1;
            n_neg_pend = i_stage.neg;
            n_idx      = top_digit(i_stage.bcd);
            n_bcd      = i_stage.bcd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active   <= 1'b0;
            r_neg_pend <= 1'b0;
        end else begin
            r_active   <= n_active;
            r_neg_pend <= n_neg_pend;
            r_idx      <= n_idx;
            r_bcd      <= n_bcd;
        end
    end

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_idx < t_idx'(NUM_DIGITS)))
        else $error("digit index out of range");

    a_minus_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_character == CHAR_MINUS) |-> !o_last_char)
        else $error("minus sign marked as last character");

    a_minus_then_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_character == CHAR_MINUS) |=>
            (o_strobe && o_character != CHAR_ZERO && o_character != CHAR_MINUS))
        else $error("minus sign not followed by a leading nonzero digit");

endmodule

>>> hdl/signed_int_to_decimal_ascii_core.sv
// Signed 32-bit integer to decimal ASCII text, most significant character first.
// Path: input register, dabble stages, then the serializer strobes the first character.
// Throughput: one character per cycle; an item of n characters (1 to 11) holds
//   the output serializer until its last character, so busy follows from text length.
// Reset: synchronous, active low; clears all valid bits. Results cannot be stalled.
`timescale 1ns / 1ps

module signed_int_to_decimal_ascii_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] i_value,
    output logic        o_strobe,
    output logic [7:0]  o_character,
    output logic        o_last_char
);
    import sitda_pkg::*;

    t_dd  r_in;
    t_dd  n_in;
    t_dd  w_stage [NUM_STAGES+1];
    logic w_ready [NUM_STAGES+1];
    logic w_in_ready;

    always_comb begin
        n_in.valid = start;
        n_in.neg   = i_value[VALUE_W-1];
        n_in.bin   = i_value[VALUE_W-1] ? (VALUE_W'(0) - i_value) : i_value;
        n_in.bcd   = '0;
    end

    assign w_in_ready = !r_in.valid || w_ready[0];
    assign busy       = !w_in_ready;
    assign w_stage[0] = r_in;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in.valid <= 1'b0;
        end else if (w_in_ready) begin
            r_in <= n_in;
        end
    end

    for (genvar k = 0; k < NUM_STAGES; k++) begin : g_dd
        sitda_dabble_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_stage (w_stage[k]),
            .i_ready (w_ready[k+1]),
            .o_stage (w_stage[k+1]),
            .o_ready (w_ready[k])
        );
    end

    sitda_serializer u_ser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_stage     (w_stage[NUM_STAGES]),
        .o_ready     (w_ready[NUM_STAGES]),
        .o_strobe    (o_strobe),
        .o_character (o_character),
        .o_last_char (o_last_char)
    );

endmodule

>>> bench/signed_int_to_decimal_ascii_core_tb.sv
// Testbench for signed_int_to_decimal_ascii_core: directed table, then random values.
// Characters are predicted in the bench and checked in order as they are strobed.
// Depends on sitda_pkg and signed_int_to_decimal_ascii_core.
`timescale 1ns / 1ps

module signed_int_to_decimal_ascii_core_tb;

    import sitda_pkg::*;

    localparam int N_DIR      = 18;
    localparam int N_RANDOM   = 452;
    localparam int QUIET_MAX  = 500;
    localparam int DRAIN_WAIT = 24;

    typedef struct {
        logic [7:0] character;
        logic       last_char;
    } t_text_char;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [31:0] i_value;
    logic        o_strobe;
    logic [7:0]  o_character;
    logic        o_last_char;

    t_text_char  pending_chars[$];
    int          fail_count;
    int          quiet_cycles;
    int          idle_pct;

    // Expected text is typed in where it is plain; empty rows go to the predictor.
    logic [31:0] dir_value [N_DIR] = '{
        32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, 32'd10, 32'hFFFF_FFF6,
        32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'd999_999_999,
        32'd1_000_000_000, 32'd99, 32'd100, 32'hFFFF_FF9C,
        32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_FFFF, 32'hFFFF_0000
    };
    string       dir_text [N_DIR] = '{
        "0", "1", "-1", "9", "10", "-10",
        "2147483647", "-2147483648", "-2147483647", "999999999",
        "1000000000", "", "", "",
        "", "", "", ""
    };

    signed_int_to_decimal_ascii_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_value     (i_value),
        .o_strobe    (o_strobe),
        .o_character (o_character),
        .o_last_char (o_last_char)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic predict_text(input logic [31:0] value);
        logic [31:0] mag;
        logic [7:0]  digits [10];
        int          ndig;
        t_text_char  c;
        mag  = value[31] ? (32'd0 - value) : value;
        ndig = 0;
        do begin
            digits[ndig] = CHAR_ZERO + 8'(mag % 32'd10);
            ndig++;
            mag = mag / 32'd10;
        end while (mag != 32'd0 && ndig < 10);
        if (value[31]) begin
            c.character = CHAR_MINUS;
            c.last_char = 1'b0;
            pending_chars.push_back(c);
        end
        for (int k = ndig - 1; k >= 0; k--) begin
            c.character = digits[k];
            c.last_char = (k == 0);
            pending_chars.push_back(c);
        end
    endtask

    task automatic send_value(input logic [31:0] value, input string text);
        t_text_char c;
        while ($urandom_range(1, 100) <= idle_pct) begin
            @(negedge i_clk);
            start   <= 1'b0;
            i_value <= $urandom;
        end
        @(negedge i_clk);
        start   <= 1'b1;
        i_value <= value;
        do @(posedge i_clk); while (busy !== 1'b0);
        if (text.len() > 0) begin
            for (int k = 0; k < text.len(); k++) begin
                c.character = text[k];
                c.last_char = (k == text.len() - 1);
                pending_chars.push_back(c);
            end
        end else begin
            predict_text(value);
        end
    endtask

    always @(posedge i_clk) begin
        t_text_char exp_c;
        if (i_rst_n === 1'b1 && o_strobe === 1'b1) begin
            if (pending_chars.size() == 0) begin
                $error("unexpected character transfer: character %h last_char %b",
                       o_character, o_last_char);
                fail_count++;
            end else begin
                exp_c = pending_chars.pop_front();
                if (o_character !== exp_c.character) begin
                    $error("character: expected %h actual %h", exp_c.character, o_character);
                    fail_count++;
                end
                if (o_last_char !== exp_c.last_char) begin
                    $error("last_char: expected %b actual %b", exp_c.last_char, o_last_char);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start === 1'b1 && busy === 1'b0) || o_strobe === 1'b1) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_MAX) begin
            $display("status: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        logic [31:0] mag;
        logic [31:0] value;
        int          phase_pct [3];
        phase_pct    = '{0, 53, 22};
        fail_count   = 0;
        quiet_cycles = 0;
        idle_pct     = 0;
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_value      = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int r = 0; r < N_DIR; r++) begin
            send_value(dir_value[r], dir_text[r]);
        end

        for (int p = 0; p < 3; p++) begin
            idle_pct = phase_pct[p];
            for (int n = 0; n < N_RANDOM / 3; n++) begin
                if ($urandom_range(0, 3) == 0) begin
                    value = $urandom;
                end else begin
                    mag   = $urandom >> $urandom_range(0, 31);
                    value = $urandom_range(0, 1) ? (32'd0 - mag) : mag;
                end
                send_value(value, "");
            end
        end

        @(negedge i_clk);
        start <= 1'b0;
        while (pending_chars.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
